FILE: hw/rtl/hsl2rgb_pkg.sv
// hsl2rgb_pkg: shared types and constants for the hsl to rgb converter
// transaction payload structs and the default fraction width; no dependencies
`default_nettype none

package hsl2rgb_pkg;

  localparam int FIELD_W           = 16;
  localparam int FRAC_BITS_DEFAULT = 16;

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  // ramp segment of one channel
  typedef logic [1:0] seg_t;
  localparam seg_t SEG_RISE = 2'd0;
  localparam seg_t SEG_HIGH = 2'd1;
  localparam seg_t SEG_FALL = 2'd2;
  localparam seg_t SEG_LOW  = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/hsl_to_rgb_convert.sv
// hsl_to_rgb_convert: pipelined hsl to rgb pixel converter, top level
// uses hsl2rgb_pkg for payload types, segment codes and defaults
`default_nettype none

// Converts one hue, saturation, lightness pixel into one red, green, blue pixel,
// all values unsigned fractions of one with FRAC_BITS fraction bits (inputs are
// taken at their low FRAC_BITS bits, outputs are the low 16 bits of the result).
// The block accepts one transaction every clock unless held by an output stall.
// Its stages, in order, are the input register, the lightness times
// saturation multiplier, blend levels and hue segments, three channel ramp
// multipliers, and the output register. A stage holds its item only while the
// stage after it is full and held, so a stall at the output reaches the input
// in the same cycle, empty stages still fill, and no transaction is lost or
// repeated. The block keeps no state between pixels.

module hsl_to_rgb_convert #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               hsl_valid,
  output logic              hsl_ready,
  input  hsl2rgb_pkg::hsl_t hsl,
  output logic              rgb_valid,
  input  wire               rgb_ready,
  output hsl2rgb_pkg::rgb_t rgb
);

  localparam int F = FRAC_BITS;

  localparam logic [F-1:0] THIRD      = F'((1 << F) / 3);
  localparam logic [F-1:0] SIXTH      = F'((1 << F) / 6);
  localparam logic [F-1:0] HALF       = F'((1 << F) / 2);
  localparam logic [F-1:0] TWO_THIRDS = F'((2 * (1 << F)) / 3);
  localparam logic [F-1:0] MASK       = F'((1 << F) - 1);

  // stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5       = !v5 || rgb_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign hsl_ready = en1;
  assign rgb_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= hsl_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: input register
  logic [F-1:0] h1, s1, l1;
  logic         grey1;
  logic [F-1:0] s_in;

  assign s_in = F'(hsl.saturation);

  always_ff @(posedge clk) begin
    if (en1) begin
      h1    <= F'(hsl.hue);
      s1    <= s_in;
      l1    <= F'(hsl.lightness);
      grey1 <= (s_in == '0);
    end
  end

  // stage 2: lightness times saturation
  logic [2*F-1:0] ls_full;
  logic [F-1:0]   prod2, h2, s2, l2;
  logic           grey2;

  assign ls_full = {{F{1'b0}}, l1} * {{F{1'b0}}, s1};

  always_ff @(posedge clk) begin
    if (en2) begin
      prod2 <= ls_full[2*F-1:F];
      h2    <= h1;
      s2    <= s1;
      l2    <= l1;
      grey2 <= grey1;
    end
  end

  // stage 3: blend levels and per channel segment and ramp factor
  logic [F:0]   hi_sum;
  logic [F-1:0] hi_next, lo_next;
  logic [F:0]   lo_full;
  logic [F-1:0] t_ch [3];
  logic [F-1:0] d_ch [3];
  hsl2rgb_pkg::seg_t seg_next [3];
  logic [F:0]   fac_next [3];

  always_comb begin
    if (l2 < HALF) begin
      hi_sum = {1'b0, l2} + {1'b0, prod2};
    end else begin
      hi_sum = {1'b0, l2} + {1'b0, s2} - {1'b0, prod2};
    end
    hi_next = hi_sum[F] ? MASK : hi_sum[F-1:0];
    lo_full = {l2, 1'b0} - {1'b0, hi_next};
    lo_next = lo_full[F-1:0];
  end

  always_comb begin
    t_ch[0] = h2 + THIRD;
    t_ch[1] = h2;
    t_ch[2] = h2 - THIRD;
    for (int c = 0; c < 3; c++) begin
      d_ch[c] = TWO_THIRDS - t_ch[c];
      priority if (t_ch[c] < SIXTH) begin
        seg_next[c] = hsl2rgb_pkg::SEG_RISE;
        fac_next[c] = (F+1)'({t_ch[c], 2'b00}) + (F+1)'({t_ch[c], 1'b0});
      end else if (t_ch[c] < HALF) begin
        seg_next[c] = hsl2rgb_pkg::SEG_HIGH;
        fac_next[c] = '0;
      end else if (t_ch[c] < TWO_THIRDS) begin
        seg_next[c] = hsl2rgb_pkg::SEG_FALL;
        fac_next[c] = (F+1)'({d_ch[c], 2'b00}) + (F+1)'({d_ch[c], 1'b0});
      end else begin
        seg_next[c] = hsl2rgb_pkg::SEG_LOW;
        fac_next[c] = '0;
      end
    end
  end

  logic [F-1:0]      hi3, lo3, span3, l3;
  logic              grey3;
  hsl2rgb_pkg::seg_t seg3 [3];
  logic [F:0]        fac3 [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      hi3   <= hi_next;
      lo3   <= lo_next;
      span3 <= hi_next - lo_next;
      l3    <= l2;
      grey3 <= grey2;
      for (int c = 0; c < 3; c++) begin
        seg3[c] <= seg_next[c];
        fac3[c] <= fac_next[c];
      end
    end
  end

  // stage 4: channel ramp products
  logic [2*F:0]      mul_ch [3];
  logic [F-1:0]      p4 [3];
  logic [F-1:0]      hi4, lo4, l4;
  logic              grey4;
  hsl2rgb_pkg::seg_t seg4 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul_ch[c] = {{(F+1){1'b0}}, span3} * {{F{1'b0}}, fac3[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hi4   <= hi3;
      lo4   <= lo3;
      l4    <= l3;
      grey4 <= grey3;
      for (int c = 0; c < 3; c++) begin
        p4[c]   <= mul_ch[c][2*F-1:F];
        seg4[c] <= seg3[c];
      end
    end
  end

  // stage 5: channel select and output register
  logic [F-1:0]      ch_val [3];
  hsl2rgb_pkg::rgb_t rgb_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (grey4) begin
        ch_val[c] = l4;
      end else begin
        unique case (seg4[c])
          hsl2rgb_pkg::SEG_RISE: ch_val[c] = lo4 + p4[c];
          hsl2rgb_pkg::SEG_HIGH: ch_val[c] = hi4;
          hsl2rgb_pkg::SEG_FALL: ch_val[c] = lo4 + p4[c];
          hsl2rgb_pkg::SEG_LOW:  ch_val[c] = lo4;
          default:               ch_val[c] = lo4;
        endcase
      end
    end
    rgb_next.red   = hsl2rgb_pkg::FIELD_W'(ch_val[0]);
    rgb_next.green = hsl2rgb_pkg::FIELD_W'(ch_val[1]);
    rgb_next.blue  = hsl2rgb_pkg::FIELD_W'(ch_val[2]);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rgb <= rgb_next;
    end
  end

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && hsl_ready |=> v1)
    else $error("accepted transaction did not enter stage 1");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && v5 && !rgb_ready |-> !hsl_ready)
    else $error("full pipeline accepted a transaction while stalled");

  a_blend_order: assert property (@(posedge clk) disable iff (rst)
    v4 && !grey4 |-> lo4 <= hi4)
    else $error("lower blend level above upper blend level");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    v4 && grey4 && en5 |=> rgb.red == rgb.green && rgb.green == rgb.blue)
    else $error("grey pixel with unequal channels");

endmodule

`default_nettype wire

FILE: tb/sv/tb_hsl_to_rgb_convert.sv
// tb_hsl_to_rgb_convert: self-checking testbench for the hsl to rgb pixel converter
// drives hsl transactions, predicts each rgb result and checks it in order
// depends on hsl2rgb_pkg and hsl_to_rgb_convert
`timescale 1ns / 1ps

module tb_hsl_to_rgb_convert;

  localparam int FB = hsl2rgb_pkg::FRAC_BITS_DEFAULT;
  localparam int FW = hsl2rgb_pkg::FIELD_W;
  localparam bit [63:0] FRAC_ONE   = 64'd1 << FB;
  localparam bit [63:0] FRAC_MASK  = FRAC_ONE - 64'd1;
  localparam bit [63:0] THIRD      = FRAC_ONE / 3;
  localparam bit [63:0] SIXTH      = FRAC_ONE / 6;
  localparam bit [63:0] HALF       = FRAC_ONE / 2;
  localparam bit [63:0] TWO_THIRDS = (2 * FRAC_ONE) / 3;
  localparam int TAIL_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hsl_valid = 1'b0;
  logic hsl_ready;
  hsl2rgb_pkg::hsl_t hsl_px = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  hsl2rgb_pkg::rgb_t rgb_px;

  hsl2rgb_pkg::hsl_t pixel_queue[$];
  hsl2rgb_pkg::rgb_t rgb_expect_q[$];
  int   items_queued = 0;
  int   accepted_cnt = 0;
  int   mismatch_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  hsl_to_rgb_convert dut (
    .clk       (clk),
    .rst       (rst),
    .hsl_valid (hsl_valid),
    .hsl_ready (hsl_ready),
    .hsl       (hsl_px),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb_px)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [63:0] ramp_level(bit [63:0] t, bit [63:0] lo, bit [63:0] hi);
    bit [63:0] span;
    span = hi - lo;
    if (t < SIXTH) return lo + ((span * (6 * t)) >> FB);
    if (t < HALF) return hi;
    if (t < TWO_THIRDS) return lo + ((span * (6 * (TWO_THIRDS - t))) >> FB);
    return lo;
  endfunction

  function automatic hsl2rgb_pkg::rgb_t hsl_to_rgb_predict(hsl2rgb_pkg::hsl_t px);
    bit [63:0] h, s, l, prod, hi, lo, r, g, b;
    hsl2rgb_pkg::rgb_t res;
    h = 64'(px.hue) & FRAC_MASK;
    s = 64'(px.saturation) & FRAC_MASK;
    l = 64'(px.lightness) & FRAC_MASK;
    if (s == 0) begin
      r = l;
      g = l;
      b = l;
    end else begin
      prod = (l * s) >> FB;
      hi = (l < HALF) ? l + prod : l + s - prod;
      if (hi > FRAC_MASK) hi = FRAC_MASK;
      lo = 2 * l - hi;
      r = ramp_level((h + THIRD) & FRAC_MASK, lo, hi);
      g = ramp_level(h, lo, hi);
      b = ramp_level((h + FRAC_ONE - THIRD) & FRAC_MASK, lo, hi);
    end
    res.red   = r[FW-1:0];
    res.green = g[FW-1:0];
    res.blue  = b[FW-1:0];
    return res;
  endfunction

  // random fraction, often near a ramp boundary
  function automatic logic [FW-1:0] pick_frac();
    bit [63:0] base;
    case ($urandom_range(7))
      0: base = 0;
      1: base = SIXTH;
      2: base = THIRD;
      3: base = HALF;
      4: base = TWO_THIRDS;
      5: base = FRAC_ONE - THIRD;
      6: base = FRAC_MASK;
      default: return FW'($urandom);
    endcase
    return FW'(base + $urandom_range(6) - 3);
  endfunction

  task automatic push_pixel(bit [63:0] h, bit [63:0] s, bit [63:0] l);
    hsl2rgb_pkg::hsl_t px;
    px.hue        = h[FW-1:0];
    px.saturation = s[FW-1:0];
    px.lightness  = l[FW-1:0];
    pixel_queue.push_back(px);
    items_queued++;
  endtask

  task automatic push_random(int n);
    hsl2rgb_pkg::hsl_t px;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        px = hsl2rgb_pkg::hsl_t'(48'({$urandom, $urandom}));
      end else begin
        px.hue        = pick_frac();
        px.saturation = ($urandom_range(9) == 0) ? '0 : pick_frac();
        px.lightness  = pick_frac();
      end
      pixel_queue.push_back(px);
      items_queued++;
    end
  endtask

  task automatic wait_accepted();
    while (accepted_cnt != items_queued) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else begin
      if (hsl_valid && hsl_ready) begin
        rgb_expect_q.push_back(hsl_to_rgb_predict(hsl_px));
        accepted_cnt++;
      end
      if (!hsl_valid || hsl_ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          hsl_px    <= pixel_queue.pop_front();
          hsl_valid <= 1'b1;
        end else begin
          hsl_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk) begin
    hsl2rgb_pkg::rgb_t exp_px;
    if (rst) begin
      rgb_ready <= 1'b0;
    end else begin
      rgb_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (rgb_valid && rgb_ready) begin
        if (rgb_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected rgb transaction r=%h g=%h b=%h",
                     rgb_px.red, rgb_px.green, rgb_px.blue);
        end else begin
          exp_px = rgb_expect_q.pop_front();
          if (rgb_px.red !== exp_px.red || rgb_px.green !== exp_px.green ||
              rgb_px.blue !== exp_px.blue) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("rgb mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       exp_px.red, exp_px.green, exp_px.blue,
                       rgb_px.red, rgb_px.green, rgb_px.blue);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, grey, blend overflow, ramp boundaries, hue wrap
    push_pixel(0, 0, 0);
    push_pixel(FRAC_MASK, 0, FRAC_MASK);
    push_pixel(16'h1234, 0, HALF);
    push_pixel(0, FRAC_MASK, HALF);
    push_pixel(0, FRAC_MASK, FRAC_MASK);
    push_pixel(FRAC_MASK, FRAC_MASK, FRAC_MASK);
    push_pixel(0, 1, 1);
    push_pixel(16'h5555, FRAC_MASK, HALF - 1);
    push_pixel(SIXTH - 1, FRAC_MASK, HALF - 1);
    push_pixel(SIXTH, 16'h8000, HALF);
    push_pixel(HALF - 1, 16'hc000, 16'h4000);
    push_pixel(HALF, 16'h4000, 16'hc000);
    push_pixel(TWO_THIRDS - 1, FRAC_MASK, 16'h6000);
    push_pixel(TWO_THIRDS, FRAC_MASK, 16'h6000);
    push_pixel(THIRD, 16'h9999, 16'h3333);
    push_pixel(THIRD - 1, 16'h9999, 16'h3333);
    push_pixel(FRAC_ONE - THIRD, 16'haaaa, 16'h5555);
    push_pixel(FRAC_ONE - THIRD - 1, 16'haaaa, 16'h5555);
    push_pixel(FRAC_MASK, 16'h8000, 16'h4000);
    push_pixel(16'h0001, FRAC_MASK, 16'hfffe);
    push_pixel(16'haaaa, 16'h5555, FRAC_MASK);
    wait_accepted();

    // no idling, with one long receiver hold-off
    push_random(115);
    repeat (5) @(negedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_accepted();

    send_idle_pct = 68;
    push_random(115);
    wait_accepted();

    send_idle_pct  = 0;
    recv_stall_pct = 68;
    push_random(115);
    wait_accepted();

    send_idle_pct  = 35;
    recv_stall_pct = 35;
    push_random(115);
    wait_accepted();

    while (rgb_expect_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && rgb_expect_q.size() == 0) begin
      $display("hsl_to_rgb_convert verification clean");
    end else begin
      $display("hsl_to_rgb_convert verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("hsl_to_rgb_convert verification failed");
    $finish;
  end

endmodule
